@@ rtl/bresenham_line_stepper_defines.svh @@
// ============================================================================
// bresenham_line_stepper_defines.svh
// Assertion macros used by the line stepper top module.
// ============================================================================
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BLS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bls assertion failed");

// Next-cycle implication, checked out of reset
`define BLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bls assertion failed");

`endif

@@ rtl/bls_pkg.sv @@
// ============================================================================
// bls_pkg
// Shared codes and types of the line stepper.
// ============================================================================
`default_nettype none

package bls_pkg;

    // item kind codes
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // per-pixel status flags
    typedef struct packed {
        logic pixel_valid;
        logic last_pixel;
        logic swapped;
    } bls_flags_t;

endpackage

`default_nettype wire

@@ rtl/bresenham_line_stepper.sv @@
// ============================================================================
// bresenham_line_stepper
// Integer line generator: a start beat loads two endpoints and returns the
// first pixel, each step beat returns the next pixel of the line.
//
// Input channel s_*: kind (0 start, 1 step) plus two endpoints, which are
// looked at on start beats only. Output channel m_*: one beat per input
// beat with the pixel, pixel_valid (0 once the line is done or before any
// start), last_pixel and the swap flag of the line.
// Path: input register, then the result register after the setup/step logic.
// Throughput: one beat per cycle while m_ready keeps the output draining;
// the line state updates once per beat, so steps run back to back.
// Reset (aresetn low, synchronous): both registers empty, line state zero,
// so a step before any start gives pixel_valid 0.
// Stall: while m_ready is low the result register holds; the input register
// takes one more beat, then s_ready drops until the output drains.
// ============================================================================
`default_nettype none

`include "bresenham_line_stepper_defines.svh"

module bresenham_line_stepper #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic signed [COORD_BITS-1:0] s_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_end_y,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [COORD_BITS-1:0]      m_pixel_x,
    output logic signed [COORD_BITS-1:0]      m_pixel_y,
    output logic                              m_pixel_valid,
    output logic                              m_last_pixel,
    output logic                              m_swapped
);
    import bls_pkg::*;

    logic                         stg_valid;
    logic                         stg_kind;
    logic signed [COORD_BITS-1:0] stg_start_x;
    logic signed [COORD_BITS-1:0] stg_start_y;
    logic signed [COORD_BITS-1:0] stg_end_x;
    logic signed [COORD_BITS-1:0] stg_end_y;
    logic                         adv;
    logic signed [COORD_BITS-1:0] core_x;
    logic signed [COORD_BITS-1:0] core_y;
    bls_flags_t                   core_flags;

    logic                         m_valid_reg, m_valid_next;
    logic signed [COORD_BITS-1:0] m_x_reg;
    logic signed [COORD_BITS-1:0] m_y_reg;
    bls_flags_t                   m_flags_reg;

    // held beat moves on when the result register is free
    assign adv = stg_valid && (!m_valid_reg || m_ready);

    bls_in_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .s_end_x     (s_end_x),
        .s_end_y     (s_end_y),
        .adv         (adv),
        .stg_valid   (stg_valid),
        .stg_kind    (stg_kind),
        .stg_start_x (stg_start_x),
        .stg_start_y (stg_start_y),
        .stg_end_x   (stg_end_x),
        .stg_end_y   (stg_end_y)
    );

    bls_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .kind    (stg_kind),
        .start_x (stg_start_x),
        .start_y (stg_start_y),
        .end_x   (stg_end_x),
        .end_y   (stg_end_y),
        .pix_x   (core_x),
        .pix_y   (core_y),
        .flags   (core_flags)
    );

    // result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_x_reg     <= core_x;
            m_y_reg     <= core_y;
            m_flags_reg <= core_flags;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_valid = m_flags_reg.pixel_valid;
    assign m_last_pixel  = m_flags_reg.last_pixel;
    assign m_swapped     = m_flags_reg.swapped;

    // a beat taken from the input register always shows up at the output
    `BLS_ASSERT_NEXT(a_adv_fills_out, aclk, aresetn, adv, m_valid_reg)
    // a no-pixel beat carries zero coordinates and no last flag
    `BLS_ASSERT_NOW(a_idle_zero, aclk, aresetn, m_valid_reg && !m_flags_reg.pixel_valid,
        m_x_reg == '0 && m_y_reg == '0 && !m_flags_reg.last_pixel)
    // input register only blocks while a beat waits in it
    `BLS_ASSERT_NOW(a_ready_full, aclk, aresetn, !s_ready, stg_valid && m_valid_reg && !m_ready)

endmodule

`default_nettype wire

@@ rtl/bls_in_stage.sv @@
// ============================================================================
// bls_in_stage
// Input register: captures one input beat and holds it until the core
// consumes it.
// ============================================================================
`default_nettype none

module bls_in_stage #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic signed [COORD_BITS-1:0] s_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_end_y,
    input  wire logic                         adv,
    output logic                              stg_valid,
    output logic                              stg_kind,
    output logic signed [COORD_BITS-1:0]      stg_start_x,
    output logic signed [COORD_BITS-1:0]      stg_start_y,
    output logic signed [COORD_BITS-1:0]      stg_end_x,
    output logic signed [COORD_BITS-1:0]      stg_end_y
);
    import bls_pkg::*;

    logic                         valid_reg;
    logic                         valid_next;
    logic                         kind_reg;
    logic signed [COORD_BITS-1:0] start_x_reg;
    logic signed [COORD_BITS-1:0] start_y_reg;
    logic signed [COORD_BITS-1:0] end_x_reg;
    logic signed [COORD_BITS-1:0] end_y_reg;
    logic                         load;

    // free when empty or when the held beat leaves this cycle
    assign s_ready = !valid_reg || adv;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (adv) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg    <= s_kind;
            start_x_reg <= s_start_x;
            start_y_reg <= s_start_y;
            end_x_reg   <= s_end_x;
            end_y_reg   <= s_end_y;
        end
    end

    assign stg_valid   = valid_reg;
    assign stg_kind    = (kind_reg == KIND_STEP) ? KIND_STEP : KIND_START;
    assign stg_start_x = start_x_reg;
    assign stg_start_y = start_y_reg;
    assign stg_end_x   = end_x_reg;
    assign stg_end_y   = end_y_reg;

endmodule

`default_nettype wire

@@ rtl/bls_core.sv @@
// ============================================================================
// bls_core
// Line state and next-pixel logic: line setup on a start beat, one
// Bresenham step on a step beat while the line has steps left.
// ============================================================================
`default_nettype none

module bls_core #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         kind,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic signed [COORD_BITS-1:0]      pix_x,
    output logic signed [COORD_BITS-1:0]      pix_y,
    output bls_pkg::bls_flags_t               flags
);
    import bls_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = W + 1;   // deltas and step count
    localparam int HW = W + 2;   // 2*minor
    localparam int EW = W + 3;   // error term and 2*minor - 2*major

    // line state
    logic signed [W-1:0] cur_x_reg,  cur_x_next;
    logic signed [W-1:0] cur_y_reg,  cur_y_next;
    logic [EW-1:0]       err_reg,    err_next;
    logic [DW-1:0]       steps_reg,  steps_next;
    logic [HW-1:0]       hold_reg,   hold_next;
    logic [EW-1:0]       inc_reg,    inc_next;
    logic                xmaj_reg,   xmaj_next;
    logic                xneg_reg,   xneg_next;
    logic                swap_reg,   swap_next;

    // setup terms
    logic                swap_s;
    logic signed [W-1:0] x0, y0, x1, y1;
    logic [DW-1:0]       dx_raw, dx, dy;
    logic                x_pos;
    logic                x_maj_s;
    logic [DW-1:0]       major, minor;
    logic [EW-1:0]       hold_e;

    // step terms
    logic                minor_moves;
    logic signed [W-1:0] x_moved;
    logic                emit;

    // order endpoints so y rises
    assign swap_s = start_y > end_y;
    assign x0     = swap_s ? end_x   : start_x;
    assign y0     = swap_s ? end_y   : start_y;
    assign x1     = swap_s ? start_x : end_x;
    assign y1     = swap_s ? start_y : end_y;

    // deltas and axis choice, ties go y-major
    assign x_pos   = x1 > x0;
    assign dx_raw  = {x1[W-1], x1} - {x0[W-1], x0};
    assign dx      = x_pos ? dx_raw : (~dx_raw + DW'(1));
    assign dy      = {y1[W-1], y1} - {y0[W-1], y0};
    assign x_maj_s = dx > dy;
    assign major   = x_maj_s ? dx : dy;
    assign minor   = x_maj_s ? dy : dx;
    assign hold_e  = {1'b0, minor, 1'b0};

    // Bresenham decision and x move
    assign minor_moves = !err_reg[EW-1];
    assign x_moved     = xneg_reg ? (cur_x_reg - W'(1)) : (cur_x_reg + W'(1));

    always_comb begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        err_next   = err_reg;
        steps_next = steps_reg;
        hold_next  = hold_reg;
        inc_next   = inc_reg;
        xmaj_next  = xmaj_reg;
        xneg_next  = xneg_reg;
        swap_next  = swap_reg;
        emit       = 1'b0;
        case (kind)
            KIND_START: begin
                cur_x_next = x0;
                cur_y_next = y0;
                err_next   = hold_e - {2'b00, major};
                steps_next = major;
                hold_next  = hold_e[HW-1:0];
                inc_next   = hold_e - {1'b0, major, 1'b0};
                xmaj_next  = x_maj_s;
                xneg_next  = !x_pos;
                swap_next  = swap_s;
                emit       = 1'b1;
            end
            KIND_STEP: begin
                if (steps_reg != '0) begin
                    err_next   = err_reg + (minor_moves ? inc_reg : {1'b0, hold_reg});
                    steps_next = steps_reg - DW'(1);
                    if (xmaj_reg) begin
                        cur_x_next = x_moved;
                        if (minor_moves) begin
                            cur_y_next = cur_y_reg + W'(1);
                        end
                    end else begin
                        cur_y_next = cur_y_reg + W'(1);
                        if (minor_moves) begin
                            cur_x_next = x_moved;
                        end
                    end
                    emit = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // result of this beat
    assign pix_x             = emit ? cur_x_next : '0;
    assign pix_y             = emit ? cur_y_next : '0;
    assign flags.pixel_valid = emit;
    assign flags.last_pixel  = emit && (steps_next == '0);
    assign flags.swapped     = swap_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            err_reg   <= '0;
            steps_reg <= '0;
            hold_reg  <= '0;
            inc_reg   <= '0;
            xmaj_reg  <= 1'b0;
            xneg_reg  <= 1'b0;
            swap_reg  <= 1'b0;
        end else if (adv) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
            steps_reg <= steps_next;
            hold_reg  <= hold_next;
            inc_reg   <= inc_next;
            xmaj_reg  <= xmaj_next;
            xneg_reg  <= xneg_next;
            swap_reg  <= swap_next;
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the Bresenham line stepper. Start and step beats
// are queued up front and driven in bursts. Each accepted beat runs through
// a line-walk model kept in the bench, and every pixel beat that comes back
// is checked field by field against the oldest prediction.
// ============================================================================
`default_nettype none

module tb_top;

    import bls_pkg::*;

    localparam int COORD_BITS     = 16;
    localparam int COORD_MIN      = -32768;
    localparam int COORD_MAX      = 32767;
    localparam int TARGET_BEATS   = 800;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic                         kind;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } line_beat_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        bls_flags_t                   flags;
    } line_pixel_t;

    // clock and DUT ports
    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    logic                         s_kind        = KIND_START;
    logic signed [COORD_BITS-1:0] s_start_x     = '0;
    logic signed [COORD_BITS-1:0] s_start_y     = '0;
    logic signed [COORD_BITS-1:0] s_end_x       = '0;
    logic signed [COORD_BITS-1:0] s_end_y       = '0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic signed [COORD_BITS-1:0] m_pixel_x;
    logic signed [COORD_BITS-1:0] m_pixel_y;
    logic                         m_pixel_valid;
    logic                         m_last_pixel;
    logic                         m_swapped;

    // bench bookkeeping
    line_beat_t  pending_beats[$];
    line_pixel_t expected_pixels[$];
    line_pixel_t pixel_due;
    int          mismatch_count = 0;
    int          beats_queued   = 0;
    int          burst_left     = 1;
    int          gap_left       = 0;
    int          stall_mode     = 0;
    int          stall_phase    = 0;
    int          mode_left      = 50;
    int          idle_cycles    = 0;

    // line-walk model state, zero as after reset
    logic signed [COORD_BITS-1:0] pos_x        = '0;
    logic signed [COORD_BITS-1:0] pos_y        = '0;
    logic signed [18:0]           err_acc      = '0;
    logic        [16:0]           pixels_left  = '0;
    logic        [17:0]           hold_inc     = '0;
    logic signed [18:0]           step_inc     = '0;
    bit                           walk_x_major = 1'b0;
    bit                           walk_x_neg   = 1'b0;
    bit                           walk_swapped = 1'b0;

    bresenham_line_stepper #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_valid (m_pixel_valid),
        .m_last_pixel  (m_last_pixel),
        .m_swapped     (m_swapped)
    );

    always #5 aclk = ~aclk;

    // Advance the line model by one beat and return the pixel it emits
    function automatic line_pixel_t walk_line(line_beat_t beat);
        line_pixel_t px;
        int          x0, y0, x1, y1, tmp;
        int          dx, dy, major, minor;
        bit          minor_moves;
        px.pixel_x = '0;
        px.pixel_y = '0;
        if (beat.kind == KIND_START) begin
            x0 = beat.start_x;
            y0 = beat.start_y;
            x1 = beat.end_x;
            y1 = beat.end_y;
            walk_swapped = 1'b0;
            // keep y rising along the walk
            if (y0 > y1) begin
                tmp = y0; y0 = y1; y1 = tmp;
                tmp = x0; x0 = x1; x1 = tmp;
                walk_swapped = 1'b1;
            end
            dx           = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy           = y1 - y0;
            walk_x_neg   = !(x1 > x0);
            walk_x_major = dx > dy;
            major        = walk_x_major ? dx : dy;
            minor        = walk_x_major ? dy : dx;
            hold_inc     = 18'(2 * minor);
            step_inc     = 19'(2 * minor - 2 * major);
            err_acc      = 19'(2 * minor - major);
            pixels_left  = 17'(major);
            pos_x        = x0[COORD_BITS-1:0];
            pos_y        = y0[COORD_BITS-1:0];
        end else if (pixels_left == 0) begin
            // line finished or never started: empty pixel, state untouched
            px.flags.pixel_valid = 1'b0;
            px.flags.last_pixel  = 1'b0;
            px.flags.swapped     = walk_swapped;
            return px;
        end else begin
            minor_moves = !err_acc[18];
            err_acc     = minor_moves ? err_acc + step_inc
                                      : err_acc + $signed({1'b0, hold_inc});
            if (walk_x_major) begin
                if (minor_moves)
                    pos_y = pos_y + 16'sd1;
                pos_x = walk_x_neg ? pos_x - 16'sd1 : pos_x + 16'sd1;
            end else begin
                if (minor_moves)
                    pos_x = walk_x_neg ? pos_x - 16'sd1 : pos_x + 16'sd1;
                pos_y = pos_y + 16'sd1;
            end
            pixels_left = pixels_left - 17'd1;
        end
        px.pixel_x           = pos_x;
        px.pixel_y           = pos_y;
        px.flags.pixel_valid = 1'b1;
        px.flags.last_pixel  = (pixels_left == 0);
        px.flags.swapped     = walk_swapped;
        return px;
    endfunction

    function automatic int coord_clamp(int v);
        if (v < COORD_MIN)
            return COORD_MIN;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic add_start(int sx, int sy, int ex, int ey);
        line_beat_t beat;
        beat.kind    = KIND_START;
        beat.start_x = sx[COORD_BITS-1:0];
        beat.start_y = sy[COORD_BITS-1:0];
        beat.end_x   = ex[COORD_BITS-1:0];
        beat.end_y   = ey[COORD_BITS-1:0];
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    // step beats carry junk endpoints, which the block must ignore
    task automatic add_steps(int count);
        line_beat_t beat;
        repeat (count) begin
            beat.kind    = KIND_STEP;
            beat.start_x = COORD_BITS'($urandom);
            beat.start_y = COORD_BITS'($urandom);
            beat.end_x   = COORD_BITS'($urandom);
            beat.end_y   = COORD_BITS'($urandom);
            pending_beats.push_back(beat);
            beats_queued++;
        end
    endtask

    // A short random line, mostly walked to its end and a little past it
    task automatic add_random_line();
        int sx, sy, ex, ey, span, major;
        span = ($urandom_range(0, 9) == 0) ? 300 : 24;
        sx   = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? COORD_MAX : COORD_MIN)
                                           : rand_coord();
        sy   = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? COORD_MAX : COORD_MIN)
                                           : rand_coord();
        ex   = coord_clamp(sx + int'($urandom_range(0, 2 * span)) - span);
        ey   = coord_clamp(sy + int'($urandom_range(0, 2 * span)) - span);
        major = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > major)
            major = (ey > sy ? ey - sy : sy - ey);
        add_start(sx, sy, ex, ey);
        if ($urandom_range(0, 4) != 0)
            add_steps(major + $urandom_range(0, 2));
        else
            add_steps($urandom_range(0, major));
    endtask

    // Build the whole beat list, then wait for the traffic to drain
    initial begin
        // steps before any start give empty pixels
        add_steps(2);
        // single-point lines
        add_start(0, 0, 0, 0);
        add_steps(1);
        add_start(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        // full-range diagonals: tie goes y-major, swapped and negative x
        add_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        add_steps(3);
        add_start(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        add_steps(2);
        add_start(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        add_steps(2);
        // short x-major walk, then a step past the end
        add_start(0, 0, 3, 1);
        add_steps(4);
        // vertical line that needs a swap
        add_start(2, 4, 2, 1);
        add_steps(3);
        // horizontal line walking toward negative x
        add_start(1, 0, -1, 0);
        add_steps(3);

        // random traffic: mostly whole lines, some noise
        while (beats_queued < TARGET_BEATS) begin
            case ($urandom_range(0, 9))
                0: begin
                    add_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                    add_steps($urandom_range(0, 5));
                end
                1: add_steps($urandom_range(1, 3));
                default: add_random_line();
            endcase
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_beats.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Input driver: bursts of beats with random gaps in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_pixels.push_back(walk_line(pending_beats.pop_front()));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    s_valid   <= 1'b1;
                    s_kind    <= pending_beats[0].kind;
                    s_start_x <= pending_beats[0].start_x;
                    s_start_y <= pending_beats[0].start_y;
                    s_end_x   <= pending_beats[0].end_x;
                    s_end_y   <= pending_beats[0].end_y;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Output monitor and receiver backpressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("pixel beat with no prediction pending: x %0d y %0d",
                       m_pixel_x, m_pixel_y);
                mismatch_count++;
            end else begin
                pixel_due = expected_pixels.pop_front();
                check_field("pixel_x", pixel_due.pixel_x, m_pixel_x);
                check_field("pixel_y", pixel_due.pixel_y, m_pixel_y);
                check_field("pixel_valid", pixel_due.flags.pixel_valid, m_pixel_valid);
                check_field("last_pixel", pixel_due.flags.last_pixel, m_last_pixel);
                check_field("swapped", pixel_due.flags.swapped, m_swapped);
            end
        end

        // stall pattern: open, light, heavy, or periodic long stalls
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            mode_left   = mode_left - 1;
            stall_phase = stall_phase + 1;
            if (mode_left <= 0) begin
                mode_left  = $urandom_range(20, 200);
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((stall_phase % 11) < 4);
            endcase
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

`default_nettype wire
